@@ design/pixel_blend_unit_core_assert.svh @@
// Assertion macros for the pixel blend core.
`ifndef PIXEL_BLEND_UNIT_CORE_ASSERT_SVH
`define PIXEL_BLEND_UNIT_CORE_ASSERT_SVH

// Same-cycle implication, ignored during reset.
`define PBU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pbu assertion failed");

// Next-cycle implication, ignored during reset.
`define PBU_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pbu assertion failed");

// Next-cycle implication, also checked across reset.
`define PBU_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("pbu assertion failed");

`endif

@@ design/pbu_pkg.sv @@
package pbu_pkg;

  typedef enum logic [2:0] {
    OP_MULTIPLY  = 3'd0,
    OP_SCREEN    = 3'd1,
    OP_SUBTRACT  = 3'd2,
    OP_OVERLAY   = 3'd3,
    OP_ADD_ALL   = 3'd4,
    OP_ADD_CHAN  = 3'd5,
    OP_SCALE_CHAN = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    REG_OPERATION      = 2'd0,
    REG_CHANNEL_SELECT = 2'd1,
    REG_ADD_OFFSET     = 2'd2,
    REG_SCALE_FACTOR   = 2'd3
  } reg_index_t;

  localparam int NUM_CHANNELS = 3;
  localparam int CFG_DATA_W   = 9;

  typedef struct packed {
    op_t               operation;
    logic [1:0]        channel_select;
    logic signed [8:0] add_offset;
    logic [7:0]        scale_factor;
  } cfg_t;

endpackage

@@ design/pbu_cfg.sv @@
module pbu_cfg
  import pbu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.operation      <= OP_MULTIPLY;
      cfg.channel_select <= 2'd0;
      cfg.add_offset     <= 9'sd0;
      cfg.scale_factor   <= 8'd1;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_OPERATION:      cfg.operation      <= op_t'(cfg_data[2:0]);
        REG_CHANNEL_SELECT: cfg.channel_select <= cfg_data[1:0];
        REG_ADD_OFFSET:     cfg.add_offset     <= $signed(cfg_data[8:0]);
        REG_SCALE_FACTOR:   cfg.scale_factor   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

@@ design/pbu_channel.sv @@
module pbu_channel
  import pbu_pkg::*;
(
  input  cfg_t       cfg,
  input  logic       sel,
  input  logic [7:0] a,
  input  logic [7:0] b,
  output logic [7:0] result
);

  logic [7:0]        mp;
  logic [7:0]        mq;
  logic              dbl;
  logic              inv;
  logic [15:0]       prod;
  logic [16:0]       x;
  logic [24:0]       t;
  logic [8:0]        q0;
  logic [16:0]       r;
  logic [7:0]        q;
  logic [7:0]        blend;
  logic [7:0]        scaled;
  logic [7:0]        diff;
  logic signed [9:0] sum;
  logic [7:0]        added;

  // shared 8x8 multiplier operand select
  always_comb begin
    mp  = a;
    mq  = b;
    dbl = 1'b0;
    inv = 1'b0;
    case (cfg.operation)
      OP_MULTIPLY: begin
        mp = a;
        mq = b;
      end
      OP_SCREEN: begin
        mp  = ~a;
        mq  = ~b;
        inv = 1'b1;
      end
      OP_OVERLAY: begin
        dbl = 1'b1;
        if (b[7]) begin
          mp  = ~a;
          mq  = ~b;
          inv = 1'b1;
        end
      end
      OP_SCALE_CHAN: begin
        mp = a;
        mq = cfg.scale_factor;
      end
      default: ;
    endcase
  end

  assign prod = mp * mq;
  assign x    = (dbl ? {prod, 1'b0} : {1'b0, prod}) + 17'd127;

  // x / 255: estimate by x*257 >> 16, then one correction step
  assign t  = {8'd0, x} + {x, 8'd0};
  assign q0 = t[24:16];
  assign r  = x - ({q0, 8'd0} - {8'd0, q0});
  assign q  = (r >= 17'd255) ? 8'(q0 + 9'd1) : q0[7:0];

  assign blend  = inv ? ~q : q;
  assign scaled = (prod > 16'd255) ? 8'hFF : prod[7:0];
  assign diff   = (a > b) ? (a - b) : 8'd0;
  assign sum    = $signed({2'b00, a}) + 10'(cfg.add_offset);
  assign added  = (sum < 10'sd0) ? 8'd0 : ((sum > 10'sd255) ? 8'hFF : sum[7:0]);

  always_comb begin
    case (cfg.operation)
      OP_MULTIPLY, OP_SCREEN, OP_OVERLAY: result = blend;
      OP_SUBTRACT:   result = diff;
      OP_ADD_ALL:    result = added;
      OP_ADD_CHAN:   result = sel ? added : a;
      OP_SCALE_CHAN: result = sel ? scaled : a;
      default:       result = a;
    endcase
  end

endmodule

@@ design/pixel_blend_unit_core.sv @@
// Channel  | Direction | Handshake            | Payload
// input    | in        | in_valid / in_ready  | a_blue a_green a_red b_blue b_green b_red
// output   | out       | out_valid / out_ready| out_blue out_green out_red
// config   | in        | cfg_we (no wait)     | cfg_index cfg_data
//
// One pixel per clock unless out_ready stalls; out_valid is set as out_q loads.
// Stages: input register, per-channel blend logic (one 8x8 multiply), result register.
// Ready flows back through both stages, so a full pipe still accepts while output is taken.
// Sync active-high reset clears valids, sets config to defaults; data registers not reset.
`include "pixel_blend_unit_core_assert.svh"

module pixel_blend_unit_core
  import pbu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            a_blue,
  input  logic [7:0]            a_green,
  input  logic [7:0]            a_red,
  input  logic [7:0]            b_blue,
  input  logic [7:0]            b_green,
  input  logic [7:0]            b_red,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_blue,
  output logic [7:0]            out_green,
  output logic [7:0]            out_red,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t       cfg;
  logic       s1_valid;
  logic       s1_advance;
  logic [7:0] s1_a [NUM_CHANNELS];
  logic [7:0] s1_b [NUM_CHANNELS];
  logic [7:0] res  [NUM_CHANNELS];
  logic [7:0] out_q [NUM_CHANNELS];

  pbu_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign s1_advance = !out_valid || out_ready;
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_a[0] <= a_blue;
      s1_a[1] <= a_green;
      s1_a[2] <= a_red;
      s1_b[0] <= b_blue;
      s1_b[1] <= b_green;
      s1_b[2] <= b_red;
    end
  end

  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
    pbu_channel u_chan (
      .cfg    (cfg),
      .sel    (cfg.channel_select == 2'(c)),
      .a      (s1_a[c]),
      .b      (s1_b[c]),
      .result (res[c])
    );

    always_ff @(posedge clk) begin
      if (s1_valid && s1_advance) begin
        out_q[c] <= res[c];
      end
    end
  end

  assign out_blue  = out_q[0];
  assign out_green = out_q[1];
  assign out_red   = out_q[2];

  `PBU_ASSERT_IMP(a_stall_full, !in_ready, s1_valid && out_valid && !out_ready)
  `PBU_ASSERT_NXT(a_accept_fill, in_valid && in_ready, s1_valid)
  `PBU_ASSERT_NXT(a_stage_move, s1_valid && s1_advance, out_valid)
  `PBU_ASSERT_RST(a_reset_empty, rst, !out_valid && !s1_valid)

endmodule

@@ verif/testbench.sv @@
module testbench
  import pbu_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASES         = 11;
  localparam int PHASE_ITEMS    = 100;
  localparam int DRAIN_CYCLES   = 4;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef logic [2:0][7:0] rgb_t;  // [0] blue, [1] green, [2] red

  class blend_scoreboard;
    logic [2:0]        op_code  = OP_MULTIPLY;
    logic [1:0]        chan_sel = 2'd0;
    logic signed [8:0] offset   = 9'sd0;
    logic [7:0]        scale    = 8'd1;
    rgb_t              expected_pixels [$];
    int                errors = 0;
    string             chan_name [3] = '{"out_blue", "out_green", "out_red"};

    task report(string msg);
      $display("testbench: mismatch: %s", msg);
      errors++;
    endtask

    function void write_reg(logic [1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_OPERATION:      op_code  = data[2:0];
        REG_CHANNEL_SELECT: chan_sel = data[1:0];
        REG_ADD_OFFSET:     offset   = data[8:0];
        REG_SCALE_FACTOR:   scale    = data[7:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] offset_clamp(logic [7:0] a);
      int s;
      s = int'(a) + int'(offset);
      if (s < 0) s = 0;
      if (s > 255) s = 255;
      return s[7:0];
    endfunction

    function logic [7:0] scale_clamp(logic [7:0] a);
      int p;
      p = int'(a) * int'(scale);
      return (p > 255) ? 8'd255 : p[7:0];
    endfunction

    function logic [7:0] blend_channel(logic [7:0] a, logic [7:0] b, bit sel);
      int ai;
      int bi;
      int q;
      ai = a;
      bi = b;
      case (op_code)
        OP_MULTIPLY: q = (ai * bi + 127) / 255;
        OP_SCREEN:   q = 255 - ((255 - ai) * (255 - bi) + 127) / 255;
        OP_SUBTRACT: q = (ai > bi) ? ai - bi : 0;
        OP_OVERLAY: begin
          if (bi <= 127) q = (2 * ai * bi + 127) / 255;
          else q = 255 - (2 * (255 - ai) * (255 - bi) + 127) / 255;
        end
        OP_ADD_ALL:    q = offset_clamp(a);
        OP_ADD_CHAN:   q = sel ? offset_clamp(a) : a;
        OP_SCALE_CHAN: q = sel ? scale_clamp(a) : a;
        default:       q = ai;
      endcase
      return q[7:0];
    endfunction

    function void note_pixel(rgb_t a, rgb_t b);
      rgb_t want;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        want[c] = blend_channel(a[c], b[c], chan_sel == c[1:0]);
      end
      expected_pixels = {expected_pixels, want};
    endfunction

    task check_pixel(rgb_t got);
      rgb_t want;
      if (expected_pixels.size() == 0) begin
        report($sformatf("result %h with nothing expected", got));
        return;
      end
      want = expected_pixels.pop_front();
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        if (got[c] !== want[c]) begin
          report($sformatf("%s got %h want %h", chan_name[c], got[c], want[c]));
        end
      end
    endtask

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic [7:0]            a_blue    = 8'd0;
  logic [7:0]            a_green   = 8'd0;
  logic [7:0]            a_red     = 8'd0;
  logic [7:0]            b_blue    = 8'd0;
  logic [7:0]            b_green   = 8'd0;
  logic [7:0]            b_red     = 8'd0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [7:0]            out_blue;
  logic [7:0]            out_green;
  logic [7:0]            out_red;
  logic                  cfg_we    = 1'b0;
  logic [1:0]            cfg_index = 2'd0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  blend_scoreboard sb = new;
  bit              idle_on = 1'b1;
  int              stall_left = 0;
  int              quiet_cycles = 0;

  pixel_blend_unit_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .a_blue    (a_blue),
    .a_green   (a_green),
    .a_red     (a_red),
    .b_blue    (b_blue),
    .b_green   (b_green),
    .b_red     (b_red),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_blue  (out_blue),
    .out_green (out_green),
    .out_red   (out_red),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // receiver: random stall bursts on out_ready
  always @(posedge clk) begin
    int n;
    if (stall_left != 0) n = stall_left - 1;
    else if (idle_on && $urandom_range(0, 5) == 0) n = $urandom_range(1, 7);
    else n = 0;
    stall_left <= n;
    out_ready  <= (n == 0);
  end

  // transaction monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        sb.note_pixel({a_red, a_green, a_blue}, {b_red, b_green, b_blue});
      end
      if (out_valid && out_ready) sb.check_pixel({out_red, out_green, out_blue});
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task end_writes;
    cfg_we <= 1'b0;
  endtask

  task send_pixel(rgb_t a, rgb_t b);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    a_blue   <= a[0];
    a_green  <= a[1];
    a_red    <= a[2];
    b_blue   <= b[0];
    b_green  <= b[1];
    b_red    <= b[2];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task stop_sending;
    in_valid <= 1'b0;
  endtask

  task wait_drain;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function logic [7:0] random_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function rgb_t random_rgb();
    return {random_byte(), random_byte(), random_byte()};
  endfunction

  task load_random_config;
    logic [8:0] offs;
    logic [8:0] scl;
    case ($urandom_range(0, 4))
      0:       offs = 9'h100;
      1:       offs = 9'h101;
      2:       offs = 9'h0ff;
      3:       offs = 9'h000;
      default: offs = 9'($urandom_range(0, 511));
    endcase
    case ($urandom_range(0, 4))
      0:       scl = 9'd0;
      1:       scl = 9'd1;
      2:       scl = 9'd255;
      default: scl = 9'($urandom_range(0, 255));
    endcase
    write_reg(REG_OPERATION, 9'($urandom_range(0, 7)));
    write_reg(REG_CHANNEL_SELECT, 9'($urandom_range(0, 3)));
    write_reg(REG_ADD_OFFSET, offs);
    write_reg(REG_SCALE_FACTOR, scl);
    end_writes();
  endtask

  localparam logic [23:0] DIR_A [3] = '{24'hff8000, 24'hffffff, 24'hfe7f01};
  localparam logic [23:0] DIR_B [3] = '{24'h007fff, 24'h01ff80, 24'h7f8000};

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: every operation code, register defaults first
    for (int op = 0; op < 8; op++) begin
      if (op != 0) begin
        write_reg(REG_OPERATION, 9'(op));
        if (op == OP_ADD_ALL) write_reg(REG_ADD_OFFSET, 9'h100);
        if (op == OP_ADD_CHAN) begin
          write_reg(REG_CHANNEL_SELECT, 9'd2);
          write_reg(REG_ADD_OFFSET, 9'h0ff);
        end
        if (op == OP_SCALE_CHAN) begin
          write_reg(REG_CHANNEL_SELECT, 9'd3);
          write_reg(REG_SCALE_FACTOR, 9'd255);
        end
        end_writes();
      end
      for (int i = 0; i < 3; i++) send_pixel(DIR_A[i], DIR_B[i]);
      stop_sending();
      wait_drain();
    end

    // random phases, one register setting each
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES - 1) idle_on = 1'b0;
      load_random_config();
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 3 && i == PHASE_ITEMS / 2) begin
          stop_sending();
          wait_drain();
        end
        send_pixel(random_rgb(), random_rgb());
      end
      stop_sending();
      wait_drain();
    end

    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
